// ===== rtl/core/tcd_pkg.sv =====
`default_nettype none

package tcd_pkg;

	// fixed field widths
	localparam int CHAN_W  = 3;
	localparam int LIMIT_W = 8;
	localparam int EVENT_W = 2;
	localparam int CFG_W   = 4;

	// operation codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CONFIG = 1'b1;

	// event codes
	localparam logic [EVENT_W-1:0] EVT_NONE    = 2'd0;
	localparam logic [EVENT_W-1:0] EVT_TOUCH   = 2'd1;
	localparam logic [EVENT_W-1:0] EVT_RELEASE = 2'd2;

	// reset value of the channels-in-use register
	localparam logic [CFG_W-1:0] CHANNELS_IN_USE_RST = 4'd8;

	// baseline filter: new = (base * (BaseDiv - 1) + raw) / BaseDiv
	localparam int BaseDiv = 100;

endpackage

`default_nettype wire

// ===== rtl/core/tcd_item_if.sv =====
`default_nettype none

interface tcd_item_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [tcd_pkg::CHAN_W-1:0]   chan_index;
	logic [SAMPLE_BITS-1:0]       raw_sample;
	logic [SAMPLE_BITS-1:0]       base_level;
	logic [SAMPLE_BITS-1:0]       touch_threshold;
	logic [tcd_pkg::LIMIT_W-1:0]  debounce_limit;
	logic                         drift_enable;

	modport source (
		output valid, operation, chan_index, raw_sample, base_level,
		       touch_threshold, debounce_limit, drift_enable,
		input  ready
	);
	modport sink (
		input  valid, operation, chan_index, raw_sample, base_level,
		       touch_threshold, debounce_limit, drift_enable,
		output ready
	);
endinterface

interface tcd_result_if #(
	parameter int SAMPLE_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic [tcd_pkg::CHAN_W-1:0]   out_channel;
	logic                         accepted;
	logic [tcd_pkg::EVENT_W-1:0]  event_kind;
	logic signed [SAMPLE_BITS:0]  delta_value;
	logic                         touched_flag;
	logic [SAMPLE_BITS-1:0]       last_raw;

	modport source (
		output valid, out_channel, accepted, event_kind, delta_value,
		       touched_flag, last_raw,
		input  ready
	);
	modport sink (
		input  valid, out_channel, accepted, event_kind, delta_value,
		       touched_flag, last_raw,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/touch_channel_detector.sv =====
`default_nettype none

// Multi-channel capacitive touch detector. Each input word either configures
// one channel (baseline, threshold, debounce limit, drift enable) or carries
// one raw ADC sample for it, and each word gives exactly one result word with
// the channel's delta, last raw value, touched flag and any touch or release
// event. One word is accepted per clock cycle unless results stall; it passes
// an input register, then the result register. The per-channel state lives
// in flip-flops that are read and updated in the cycle a word leaves the input
// register, so words for the same channel may follow each other directly.
// Samples for channels at or above channels_in_use come back with accepted
// low and no state change. Write cfg_wdata only while no word is in flight.
module touch_channel_detector #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [tcd_pkg::CFG_W-1:0]     cfg_wdata,
	tcd_item_if.sink                     items,
	tcd_result_if.source                 results
);

	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SB     = SAMPLE_BITS;
	localparam int LW     = tcd_pkg::LIMIT_W;
	// filter numerator width: (2^SB-1)*100 fits in SB+7 bits
	localparam int NUM_W  = SB + 7;
	// reciprocal of the divisor; exact floor for every NUM_W-bit numerator
	localparam int REC_SH = NUM_W + 7;
	localparam longint unsigned REC_M =
		((64'd1 << REC_SH) + tcd_pkg::BaseDiv - 1) / tcd_pkg::BaseDiv;
	localparam int PROD_W = 2 * NUM_W + 1;

	// configuration register
	logic [tcd_pkg::CFG_W-1:0] chan_use_q;

	// input stage
	logic                          valid_s1;
	logic                          op_s1;
	logic [tcd_pkg::CHAN_W-1:0]    chan_s1;
	logic [SB-1:0]                 raw_s1;
	logic [SB-1:0]                 base_s1;
	logic [SB-1:0]                 thr_s1;
	logic [LW-1:0]                 lim_s1;
	logic                          drift_s1;

	// result register
	logic                          res_valid_q;
	logic [tcd_pkg::CHAN_W-1:0]    res_chan_q;
	logic                          res_acc_q;
	logic [tcd_pkg::EVENT_W-1:0]   res_evt_q;
	logic signed [SB:0]            res_delta_q;
	logic                          res_touch_q;
	logic [SB-1:0]                 res_raw_q;

	// per-channel state
	logic [SB-1:0]                 baseline_q [CHANNELS];
	logic [SB-1:0]                 threshold_q[CHANNELS];
	logic [LW-1:0]                 limit_q    [CHANNELS];
	logic                          drift_q    [CHANNELS];
	logic                          touched_q  [CHANNELS];
	logic [LW-1:0]                 count_q    [CHANNELS];
	logic signed [SB:0]            delta_q    [CHANNELS];
	logic [SB-1:0]                 raw_q      [CHANNELS];

	logic                          res_free;
	logic                          fire_s1;
	logic                          ch_ok;
	logic                          in_use;
	logic [CH_W-1:0]               idx;

	logic [SB-1:0]                 base_cur;
	logic [SB-1:0]                 thr_cur;
	logic [LW-1:0]                 lim_cur;
	logic                          drift_cur;
	logic                          touch_cur;
	logic [LW-1:0]                 cnt_cur;

	logic signed [SB:0]            delta_new;
	logic                          above;
	logic [LW-1:0]                 cnt_inc;
	logic                          hit;
	logic                          touch_nxt;
	logic [LW-1:0]                 cnt_nxt;
	logic [tcd_pkg::EVENT_W-1:0]   evt_nxt;

	logic [NUM_W-1:0]              filt_num;
	logic [PROD_W-1:0]             filt_prod;
	logic [SB-1:0]                 base_filt;

	logic                          acc_nxt;
	logic signed [SB:0]            delta_out;
	logic                          touch_out;
	logic [SB-1:0]                 raw_out;
	logic [tcd_pkg::EVENT_W-1:0]   evt_out;

	// handshake: result slot frees when empty or taken this cycle
	assign res_free    = !res_valid_q || results.ready;
	assign fire_s1     = valid_s1 && res_free;
	assign items.ready = !valid_s1 || res_free;

	// channel decode
	assign ch_ok  = 32'(chan_s1) < CHANNELS;
	assign in_use = {1'b0, chan_s1} < chan_use_q;
	assign idx    = CH_W'(chan_s1);

	assign base_cur  = baseline_q[idx];
	assign thr_cur   = threshold_q[idx];
	assign lim_cur   = limit_q[idx];
	assign drift_cur = drift_q[idx];
	assign touch_cur = touched_q[idx];
	assign cnt_cur   = count_q[idx];

	// delta against the old baseline
	assign delta_new = $signed({1'b0, base_cur}) - $signed({1'b0, raw_s1});
	assign above     = delta_new > $signed({1'b0, thr_cur});
	assign cnt_inc   = cnt_cur + {{(LW-1){1'b0}}, 1'b1};
	assign hit       = cnt_inc >= lim_cur;

	// baseline filter: base*99 as base*(64+32+2+1), then reciprocal multiply
	assign filt_num  = (NUM_W'(base_cur) << 6) + (NUM_W'(base_cur) << 5)
	                 + (NUM_W'(base_cur) << 1) + NUM_W'(base_cur) + NUM_W'(raw_s1);
	assign filt_prod = PROD_W'(filt_num) * PROD_W'(REC_M);
	assign base_filt = filt_prod[REC_SH +: SB];

	// debounce
	always_comb begin
		touch_nxt = touch_cur;
		cnt_nxt   = cnt_cur;
		evt_nxt   = tcd_pkg::EVT_NONE;
		if (above) begin
			if (!touch_cur) begin
				if (hit) begin
					touch_nxt = 1'b1;
					cnt_nxt   = '0;
					evt_nxt   = tcd_pkg::EVT_TOUCH;
				end else begin
					cnt_nxt = cnt_inc;
				end
			end
		end else if (touch_cur) begin
			if (hit) begin
				touch_nxt = 1'b0;
				cnt_nxt   = '0;
				evt_nxt   = tcd_pkg::EVT_RELEASE;
			end else begin
				cnt_nxt = cnt_inc;
			end
		end else begin
			cnt_nxt = '0;
		end
	end

	// result word
	always_comb begin
		acc_nxt   = 1'b0;
		evt_out   = tcd_pkg::EVT_NONE;
		delta_out = '0;
		touch_out = 1'b0;
		raw_out   = '0;
		if (ch_ok) begin
			if (op_s1 == tcd_pkg::OP_CONFIG) begin
				acc_nxt   = 1'b1;
				delta_out = delta_q[idx];
				raw_out   = raw_q[idx];
			end else if (in_use) begin
				acc_nxt   = 1'b1;
				evt_out   = evt_nxt;
				delta_out = delta_new;
				touch_out = touch_nxt;
				raw_out   = raw_s1;
			end
		end
	end

	// hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_use_q <= tcd_pkg::CHANNELS_IN_USE_RST;
		end else if (cfg_we) begin
			chan_use_q <= cfg_wdata;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			op_s1    <= items.operation;
			chan_s1  <= items.chan_index;
			raw_s1   <= items.raw_sample;
			base_s1  <= items.base_level;
			thr_s1   <= items.touch_threshold;
			lim_s1   <= items.debounce_limit;
			drift_s1 <= items.drift_enable;
		end
	end

	// update the channel state as the word leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				baseline_q[i]  <= '0;
				threshold_q[i] <= '0;
				limit_q[i]     <= '0;
				drift_q[i]     <= 1'b0;
				touched_q[i]   <= 1'b0;
				count_q[i]     <= '0;
				delta_q[i]     <= '0;
				raw_q[i]       <= '0;
			end
		end else if (fire_s1 && ch_ok) begin
			if (op_s1 == tcd_pkg::OP_CONFIG) begin
				baseline_q[idx]  <= base_s1;
				threshold_q[idx] <= thr_s1;
				limit_q[idx]     <= lim_s1;
				drift_q[idx]     <= drift_s1;
				touched_q[idx]   <= 1'b0;
				count_q[idx]     <= '0;
			end else if (in_use) begin
				raw_q[idx]     <= raw_s1;
				delta_q[idx]   <= delta_new;
				touched_q[idx] <= touch_nxt;
				count_q[idx]   <= cnt_nxt;
				if (drift_cur && !touch_cur) begin
					baseline_q[idx] <= base_filt;
				end
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1;
		end
	end

	// load the result word
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_chan_q  <= chan_s1;
			res_acc_q   <= acc_nxt;
			res_evt_q   <= evt_out;
			res_delta_q <= delta_out;
			res_touch_q <= touch_out;
			res_raw_q   <= raw_out;
		end
	end

	assign results.valid        = res_valid_q;
	assign results.out_channel  = res_chan_q;
	assign results.accepted     = res_acc_q;
	assign results.event_kind   = res_evt_q;
	assign results.delta_value  = res_delta_q;
	assign results.touched_flag = res_touch_q;
	assign results.last_raw     = res_raw_q;

endmodule

`default_nettype wire
